>>> rtl/kmq_pkg.sv
// kmq_pkg: shared types and constants of the k-means color quantizer
// used by kmq_div, kmq_cell and kmeans_color_quantizer; no dependencies
package kmq_pkg;

   localparam int PIX_DEPTH    = 65536;
   localparam int ADDR_W       = 16;
   localparam int CNT_W        = 17;
   localparam int NUM_CLUSTERS = 16;
   localparam int CID_W        = 4;
   localparam int K_W          = 5;
   localparam int DIST_W       = 18;
   localparam int SUM_W        = 24;
   localparam int DIV_NUM_W    = 26;
   localparam int DIV_DEN_W    = 18;
   localparam int DIV_CNT_W    = 5;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic [1:0] CSR_CLUSTER_COUNT   = 2'd0;
   localparam logic [1:0] CSR_ITERATION_COUNT = 2'd1;
   localparam logic [1:0] CSR_ALPHA_ENABLED   = 2'd2;

   localparam logic [K_W-1:0] CLUSTER_COUNT_RESET   = 5'd16;
   localparam logic [7:0]     ITERATION_COUNT_RESET = 8'd10;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_QUERY   = 1'b1;
   localparam logic KIND_PALETTE = 1'b0;
   localparam logic KIND_QUERY   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_QUERY,
      S_SEED_DIV,
      S_SEED_WAIT,
      S_SEED,
      S_ROUND,
      S_ASSIGN,
      S_DRAIN,
      S_UPD_SEL,
      S_UPD_DIV,
      S_UPD_WAIT,
      S_EMIT
   } state_type;

   // word moving down the cell row
   typedef struct packed {
      logic              valid;
      logic [31:0]       pixel;
      logic [ADDR_W-1:0] addr;
      logic [DIST_W-1:0] best_dist;
      logic [CID_W-1:0]  best;
   } link_type;

   typedef struct packed {
      logic [3:0][SUM_W-1:0] sums;
      logic [CNT_W-1:0]      count;
   } stats_type;

endpackage

>>> rtl/kmq_div.sv
// kmq_div: restoring divider, one quotient bit per cycle
// depends on kmq_pkg
module kmq_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [kmq_pkg::DIV_NUM_W-1:0]     numer,
   input  logic [kmq_pkg::DIV_DEN_W-1:0]     denom,
   output logic                              done,
   output logic [kmq_pkg::DIV_NUM_W-1:0]     quotient
);
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [kmq_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [kmq_pkg::DIV_NUM_W-1:0]     num_ff, num_in;
   logic [kmq_pkg::DIV_DEN_W-1:0]     den_ff, den_in;
   logic [kmq_pkg::DIV_DEN_W-1:0]     rem_ff, rem_in;
   logic [kmq_pkg::DIV_DEN_W:0]       trial;
   logic                              fits;

   always_comb begin
      trial   = {rem_ff, num_ff[kmq_pkg::DIV_NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         rem_in = fits ? kmq_pkg::DIV_DEN_W'(trial - {1'b0, den_ff})
                       : trial[kmq_pkg::DIV_DEN_W-1:0];
         num_in = {num_ff[kmq_pkg::DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == kmq_pkg::DIV_CNT_W'(kmq_pkg::DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

>>> rtl/kmq_cell.sv
// kmq_cell: one centroid of the row; distance compare on the passing word
// plus the channel sums and member count of its cluster; depends on kmq_pkg
module kmq_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [kmq_pkg::CID_W-1:0]  cell_index,
   input  logic [kmq_pkg::K_W-1:0]    k_used,
   input  logic                       alpha_en,
   input  kmq_pkg::link_type          link_i,
   output kmq_pkg::link_type          link_o,
   input  logic                       load_en,
   input  logic [31:0]                load_color,
   output logic [31:0]                color,
   input  logic                       clear_acc,
   input  logic                       acc_en,
   input  logic [kmq_pkg::CID_W-1:0]  acc_best,
   input  logic [31:0]                acc_pixel,
   output kmq_pkg::stats_type         stats
);
   kmq_pkg::link_type          link_ff, link_in;
   kmq_pkg::stats_type         stats_ff, stats_in;
   logic [31:0]                color_ff;
   logic [7:0]                 diff [4];
   logic [15:0]                sq   [4];
   logic [kmq_pkg::DIST_W-1:0] cand_dist;
   logic                       active;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         diff[c] = (link_i.pixel[8*c +: 8] > color_ff[8*c +: 8])
                 ? link_i.pixel[8*c +: 8] - color_ff[8*c +: 8]
                 : color_ff[8*c +: 8] - link_i.pixel[8*c +: 8];
         sq[c]   = diff[c] * diff[c];
      end
      cand_dist = kmq_pkg::DIST_W'(sq[0]) + kmq_pkg::DIST_W'(sq[1])
                + kmq_pkg::DIST_W'(sq[2]) + (alpha_en ? kmq_pkg::DIST_W'(sq[3]) : '0);
      active  = {1'b0, cell_index} < k_used;
      link_in = link_i;
      if (link_i.valid && active && (cell_index == '0 || cand_dist < link_i.best_dist)) begin
         link_in.best_dist = cand_dist;
         link_in.best      = cell_index;
      end
      stats_in = stats_ff;
      if (clear_acc) begin
         stats_in = '0;
      end else if (acc_en && acc_best == cell_index) begin
         for (int c = 0; c < 4; c++) begin
            stats_in.sums[c] = stats_ff.sums[c] + kmq_pkg::SUM_W'(acc_pixel[8*c +: 8]);
         end
         stats_in.count = stats_ff.count + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
      end
      link_ff.pixel     <= link_in.pixel;
      link_ff.addr      <= link_in.addr;
      link_ff.best_dist <= link_in.best_dist;
      link_ff.best      <= link_in.best;
      stats_ff          <= stats_in;
      if (load_en) begin
         color_ff <= load_color;
      end
   end

   assign link_o = link_ff;
   assign color  = color_ff;
   assign stats  = stats_ff;

endmodule

>>> rtl/kmeans_color_quantizer.sv
// kmeans_color_quantizer: top level, sequencer, pixel and assignment stores
// depends on kmq_pkg, kmq_div, kmq_cell
//
//  channel   ports                          handshake
//  request   start, busy, req_*             taken when start & !busy
//  response  rsp_strobe, rsp_*              one word per strobe, no stall
//  config    csr_write_enable, csr_index,   taken when csr_write_enable
//            csr_write_data
//
// a load does not raise busy unless it is the last pixel; a query of a stored index after a run
// is read into asg_rd_ff, then registered onto the rsp ports in S_QUERY; a run: a seed divide,
// k seed reads, then per round one pass of the n pixels through the 16-cell row plus four mean
// divides per nonempty cluster in the shared divider, then k palette words on consecutive cycles
// busy stays high for the whole run; reset clears control state only
module kmeans_color_quantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_pixel_red,
   input  logic [7:0]  req_pixel_green,
   input  logic [7:0]  req_pixel_blue,
   input  logic [7:0]  req_pixel_alpha,
   input  logic        req_last_pixel,
   input  logic [15:0] req_query_index,
   output logic        rsp_strobe,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_cluster_id,
   output logic [7:0]  rsp_color_red,
   output logic [7:0]  rsp_color_green,
   output logic [7:0]  rsp_color_blue,
   output logic [7:0]  rsp_color_alpha,
   output logic        rsp_last_entry,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   localparam int AW = kmq_pkg::ADDR_W;
   localparam int CW = kmq_pkg::CNT_W;
   localparam int NC = kmq_pkg::NUM_CLUSTERS;
   localparam int IW = kmq_pkg::CID_W;

   logic [31:0]   pix_mem [kmq_pkg::PIX_DEPTH];
   logic [IW-1:0] asg_mem [kmq_pkg::PIX_DEPTH];

   kmq_pkg::state_type state_ff, state_in;

   logic [kmq_pkg::K_W-1:0] cc_ff;
   logic [7:0]              iter_ff;
   logic                    alpha_ff;
   logic [CW-1:0]           n_ff, n_in;
   logic                    run_done_ff, run_done_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [7:0]              round_ff, round_in;
   logic [1:0]              chan_ff, chan_in;
   logic [CW-1:0]           seg_ff, seg_in;
   logic [CW-1:0]           acc_addr_ff, acc_addr_in;
   logic [CW-1:0]           done_cnt_ff;
   logic [7:0]              vals_ff [3];

   logic          pix_we;
   logic [AW-1:0] pix_waddr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          rd_seed;
   logic          rd_valid_ff, rd_seed_ff;
   logic [AW-1:0] rd_addr_ff;
   logic [IW-1:0] seed_idx_ff;
   logic [31:0]   rd_data_ff;
   logic [IW-1:0] asg_rd_ff;

   logic          out_load;
   logic          out_kind, out_last;
   logic [IW-1:0] out_id;
   logic [31:0]   out_color;
   logic          rsp_strobe_ff, rsp_kind_ff, rsp_last_ff;
   logic [IW-1:0] rsp_id_ff;
   logic [31:0]   rsp_color_ff;

   logic                               div_start, div_done;
   logic [kmq_pkg::DIV_NUM_W-1:0]      div_num, div_quo;
   logic [kmq_pkg::DIV_DEN_W-1:0]      div_den;

   kmq_pkg::link_type  links  [NC+1];
   logic [31:0]        colors [NC];
   kmq_pkg::stats_type stats  [NC];
   logic [NC-1:0]      cell_load;
   logic [31:0]        load_color;
   logic               clear_acc;

   logic [kmq_pkg::K_W-1:0] k_used;
   logic [7:0]              rounds;
   logic                    accept;
   logic [CW-1:0]           n_eff, n_new;
   logic [IW-1:0]           sel;
   kmq_pkg::stats_type      sel_stats;
   logic [31:0]             sel_color;
   logic [31:0]             upd_color;

   assign k_used = (cc_ff == '0) ? kmq_pkg::K_W'(1)
                 : (cc_ff > kmq_pkg::K_W'(NC)) ? kmq_pkg::K_W'(NC) : cc_ff;
   assign rounds = (iter_ff == '0) ? 8'd1 : iter_ff;
   assign accept = start && state_ff == kmq_pkg::S_IDLE;
   assign busy   = state_ff != kmq_pkg::S_IDLE;
   assign sel       = idx_ff[IW-1:0];
   assign sel_stats = stats[sel];
   assign sel_color = colors[sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff    <= kmq_pkg::CLUSTER_COUNT_RESET;
         iter_ff  <= kmq_pkg::ITERATION_COUNT_RESET;
         alpha_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            kmq_pkg::CSR_CLUSTER_COUNT:   cc_ff    <= csr_write_data[kmq_pkg::K_W-1:0];
            kmq_pkg::CSR_ITERATION_COUNT: iter_ff  <= csr_write_data;
            kmq_pkg::CSR_ALPHA_ENABLED:   alpha_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      run_done_in = run_done_ff;
      idx_in      = idx_ff;
      round_in    = round_ff;
      chan_in     = chan_ff;
      seg_in      = seg_ff;
      acc_addr_in = acc_addr_ff;
      pix_we      = 1'b0;
      n_eff       = run_done_ff ? '0 : n_ff;
      pix_waddr   = n_eff[AW-1:0];
      n_new       = n_eff + CW'(n_eff < CW'(kmq_pkg::PIX_DEPTH));
      rd_en       = 1'b0;
      rd_addr     = idx_ff[AW-1:0];
      rd_seed     = 1'b0;
      div_start   = 1'b0;
      div_num     = {sel_stats.sums[chan_ff], 1'b0} + kmq_pkg::DIV_NUM_W'(sel_stats.count);
      div_den     = {sel_stats.count, 1'b0};
      clear_acc   = 1'b0;
      out_load    = 1'b0;
      out_kind    = kmq_pkg::KIND_PALETTE;
      out_id      = sel;
      out_color   = sel_color;
      out_last    = 1'b0;
      upd_color   = {alpha_ff ? div_quo[7:0] : sel_color[31:24],
                     vals_ff[2], vals_ff[1], vals_ff[0]};
      unique case (state_ff)
         kmq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_mode == kmq_pkg::MODE_QUERY) begin
                  if (run_done_ff && {1'b0, req_query_index} < n_ff) begin
                     state_in = kmq_pkg::S_QUERY;
                  end
               end else begin
                  pix_we      = n_eff < CW'(kmq_pkg::PIX_DEPTH);
                  n_in        = n_new;
                  run_done_in = 1'b0;
                  if (req_last_pixel && n_new != '0) begin
                     state_in = kmq_pkg::S_SEED_DIV;
                  end
               end
            end
         end
         kmq_pkg::S_QUERY: begin
            out_load  = 1'b1;
            out_kind  = kmq_pkg::KIND_QUERY;
            out_id    = asg_rd_ff;
            out_color = {kmq_pkg::ALPHA_OPAQUE, colors[asg_rd_ff][23:0]};
            out_last  = 1'b1;
            state_in  = kmq_pkg::S_IDLE;
         end
         kmq_pkg::S_SEED_DIV: begin
            div_start = 1'b1;
            div_num   = kmq_pkg::DIV_NUM_W'(n_ff);
            div_den   = kmq_pkg::DIV_DEN_W'(k_used);
            state_in  = kmq_pkg::S_SEED_WAIT;
         end
         kmq_pkg::S_SEED_WAIT: begin
            if (div_done) begin
               seg_in      = div_quo[CW-1:0];
               idx_in      = '0;
               acc_addr_in = '0;
               round_in    = '0;
               state_in    = kmq_pkg::S_SEED;
            end
         end
         kmq_pkg::S_SEED: begin
            if (idx_ff == CW'(k_used)) begin
               state_in = kmq_pkg::S_ROUND;
            end else begin
               rd_en       = 1'b1;
               rd_seed     = 1'b1;
               rd_addr     = acc_addr_ff[AW-1:0];
               acc_addr_in = acc_addr_ff + seg_ff;
               idx_in      = idx_ff + 1'b1;
            end
         end
         kmq_pkg::S_ROUND: begin
            clear_acc = 1'b1;
            idx_in    = '0;
            state_in  = kmq_pkg::S_ASSIGN;
         end
         kmq_pkg::S_ASSIGN: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_in == n_ff) begin
               state_in = kmq_pkg::S_DRAIN;
            end
         end
         kmq_pkg::S_DRAIN: begin
            if (done_cnt_ff == n_ff) begin
               idx_in   = '0;
               state_in = kmq_pkg::S_UPD_SEL;
            end
         end
         kmq_pkg::S_UPD_SEL: begin
            if (idx_ff == CW'(k_used)) begin
               idx_in = '0;
               if ({1'b0, round_ff} + 9'd1 >= {1'b0, rounds}) begin
                  state_in = kmq_pkg::S_EMIT;
               end else begin
                  round_in = round_ff + 1'b1;
                  state_in = kmq_pkg::S_ROUND;
               end
            end else if (sel_stats.count == '0) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               chan_in  = '0;
               state_in = kmq_pkg::S_UPD_DIV;
            end
         end
         kmq_pkg::S_UPD_DIV: begin
            div_start = 1'b1;
            state_in  = kmq_pkg::S_UPD_WAIT;
         end
         kmq_pkg::S_UPD_WAIT: begin
            if (div_done) begin
               if (chan_ff == 2'd3) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = kmq_pkg::S_UPD_SEL;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = kmq_pkg::S_UPD_DIV;
               end
            end
         end
         kmq_pkg::S_EMIT: begin
            out_load  = 1'b1;
            out_color = {alpha_ff ? sel_color[31:24] : kmq_pkg::ALPHA_OPAQUE,
                         sel_color[23:0]};
            idx_in    = idx_ff + 1'b1;
            if (idx_in == CW'(k_used)) begin
               out_last    = 1'b1;
               run_done_in = 1'b1;
               state_in    = kmq_pkg::S_IDLE;
            end
         end
         default: state_in = kmq_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kmq_pkg::S_IDLE;
         n_ff          <= '0;
         run_done_ff   <= 1'b0;
         idx_ff        <= '0;
         round_ff      <= '0;
         chan_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         rd_seed_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         done_cnt_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         n_ff          <= n_in;
         run_done_ff   <= run_done_in;
         idx_ff        <= idx_in;
         round_ff      <= round_in;
         chan_ff       <= chan_in;
         rd_valid_ff   <= rd_en && !rd_seed;
         rd_seed_ff    <= rd_en && rd_seed;
         rsp_strobe_ff <= out_load;
         if (clear_acc) begin
            done_cnt_ff <= '0;
         end else if (links[NC].valid) begin
            done_cnt_ff <= done_cnt_ff + 1'b1;
         end
      end
      seg_ff      <= seg_in;
      acc_addr_ff <= acc_addr_in;
      rd_addr_ff  <= rd_addr;
      seed_idx_ff <= sel;
      if (state_ff == kmq_pkg::S_UPD_WAIT && div_done && chan_ff != 2'd3) begin
         vals_ff[chan_ff] <= div_quo[7:0];
      end
      if (out_load) begin
         rsp_kind_ff  <= out_kind;
         rsp_id_ff    <= out_id;
         rsp_color_ff <= out_color;
         rsp_last_ff  <= out_last;
      end
   end

   // stores
   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_waddr] <= {req_pixel_alpha, req_pixel_blue, req_pixel_green,
                                req_pixel_red};
      end
      rd_data_ff <= pix_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (links[NC].valid) begin
         asg_mem[links[NC].addr] <= links[NC].best;
      end
      asg_rd_ff <= asg_mem[req_query_index];
   end

   always_comb begin
      links[0]       = '0;
      links[0].valid = rd_valid_ff;
      links[0].pixel = rd_data_ff;
      links[0].addr  = rd_addr_ff;
      load_color     = rd_seed_ff ? {kmq_pkg::ALPHA_OPAQUE, rd_data_ff[23:0]} : upd_color;
      for (int i = 0; i < NC; i++) begin
         cell_load[i] = (rd_seed_ff && seed_idx_ff == IW'(i))
                     || (state_ff == kmq_pkg::S_UPD_WAIT && div_done
                         && chan_ff == 2'd3 && sel == IW'(i));
      end
   end

   kmq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_num),
      .denom    (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   for (genvar g = 0; g < NC; g++) begin : g_cell
      kmq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IW'(g)),
         .k_used     (k_used),
         .alpha_en   (alpha_ff),
         .link_i     (links[g]),
         .link_o     (links[g+1]),
         .load_en    (cell_load[g]),
         .load_color (load_color),
         .color      (colors[g]),
         .clear_acc  (clear_acc),
         .acc_en     (links[NC].valid),
         .acc_best   (links[NC].best),
         .acc_pixel  (links[NC].pixel),
         .stats      (stats[g])
      );
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_cluster_id  = rsp_id_ff;
   assign rsp_color_red   = rsp_color_ff[7:0];
   assign rsp_color_green = rsp_color_ff[15:8];
   assign rsp_color_blue  = rsp_color_ff[23:16];
   assign rsp_color_alpha = rsp_color_ff[31:24];
   assign rsp_last_entry  = rsp_last_ff;

   a_tail_in_run: assert property (@(posedge clock) disable iff (reset)
      links[NC].valid |-> (state_ff == kmq_pkg::S_ASSIGN || state_ff == kmq_pkg::S_DRAIN))
      else $error("row output outside assignment pass");

   a_div_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == kmq_pkg::S_SEED_WAIT || state_ff == kmq_pkg::S_UPD_WAIT))
      else $error("divider finished with nobody waiting");

   a_palette_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_entry |=> !rsp_strobe)
      else $error("word after final entry");

   a_no_rsp_on_load: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == kmq_pkg::MODE_LOAD && !req_last_pixel |=> !busy)
      else $error("plain load left the block busy");

endmodule
